>>> sv/sacp_pkg.sv
// shared types, constants and tree-plru helpers for the cache tag unit
// no dependencies
`timescale 1ns / 1ps
package sacp_pkg;

    localparam int SETS = 64;
    localparam int WAYS = 8;
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int TREE_W = WAYS - 1;
    localparam int FILL_W = $clog2(WAYS + 1);
    localparam int CNT_W = 32;
    localparam int CFG_W = 4;

    localparam logic [0:0] CFG_OFFSET = 1'b0;
    localparam logic [0:0] CFG_INDEX = 1'b1;

    localparam logic [1:0] ACT_HIT = 2'd0;
    localparam logic [1:0] ACT_FILL = 2'd1;
    localparam logic [1:0] ACT_REPLACE = 2'd2;

    typedef struct packed {
        logic        operation;
        logic [63:0] address;
    } t_req;

    typedef struct packed {
        logic             hit;
        logic [2:0]       way;
        logic [1:0]       action;
        logic [CNT_W-1:0] access_count;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] write_count;
        logic [CNT_W-1:0] miss_count;
        logic [CNT_W-1:0] read_miss_count;
        logic [CNT_W-1:0] write_miss_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic update;
    } t_cmd;

    function automatic logic [TREE_W-1:0] tree_touch(input logic [TREE_W-1:0] bits,
                                                     input logic [WAY_W-1:0] way);
        int s;
        int e;
        int node;
        int m;
        logic [TREE_W-1:0] r;
        r = bits;
        s = 0;
        e = WAYS - 1;
        node = 0;
        for (int k = 0; k < WAY_W + 1; k++) begin
            if (s < e) begin
                m = (s + e + 1) / 2;
                if (int'(way) >= m) begin
                    r[node] = 1'b1;
                    node = node + m - s;
                    s = m;
                end else begin
                    r[node] = 1'b0;
                    node = node + 1;
                    e = m - 1;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [WAY_W-1:0] tree_victim(input logic [TREE_W-1:0] bits);
        int s;
        int e;
        int node;
        int m;
        s = 0;
        e = WAYS - 1;
        node = 0;
        for (int k = 0; k < WAY_W + 1; k++) begin
            if (s < e) begin
                m = (s + e + 1) / 2;
                if (bits[node]) begin
                    node = node + 1;
                    e = m - 1;
                end else begin
                    node = node + m - s;
                    s = m;
                end
            end
        end
        return WAY_W'(s);
    endfunction

endpackage

>>> sv/set_assoc_cache_tree_plru_unit.sv
// set-associative tag store with tree pseudo-lru replacement
// an accepted request's set is read into registers, then looked up and updated; the
// registered response is held valid until taken, and only then is a new request accepted
// reset: synchronous active low; counters cleared, then a clearing pass over every set's
// valid, plru and fill state with request ready low; tags not cleared
`timescale 1ns / 1ps
module set_assoc_cache_tree_plru_unit
    import sacp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);
    // configuration registers
    logic [3:0] r_offset_bits;
    logic [2:0] r_index_bits;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= 4'd6;
            r_index_bits <= 3'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OFFSET: r_offset_bits <= i_cfg_data;
                CFG_INDEX: r_index_bits <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    // last set of the clearing pass
    logic clr_last;

    // sequencing
    sacp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready),
        .o_rsp_valid(o_rsp_valid), .i_rsp_ready(i_rsp_ready),
        .i_clr_last(clr_last), .o_cmd(cmd)
    );

    // storage and lookup
    sacp_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req(i_req),
        .i_offset_bits(r_offset_bits), .i_index_bits(r_index_bits),
        .o_clr_last(clr_last), .o_rsp(o_rsp)
    );
endmodule

>>> sv/sacp_ctrl.sv
// sequencing fsm for the cache tag unit: clear, lookup, update, result hold
// depends on sacp_pkg
`timescale 1ns / 1ps
module sacp_ctrl
    import sacp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  logic i_clr_last,
    output t_cmd o_cmd
);
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK, S_OUT} t_state;
    t_state r_state;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = (r_state == S_OUT);
    assign o_cmd.clear = (r_state == S_CLEAR);
    assign o_cmd.load = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.update = (r_state == S_LOOK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            case (r_state)
                S_CLEAR: if (i_clr_last) r_state <= S_IDLE;
                S_IDLE: if (i_req_valid) r_state <= S_LOOK;
                S_LOOK: r_state <= S_OUT;
                S_OUT: if (i_rsp_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/sacp_dp.sv
// tag, valid, plru and counter storage with lookup and update datapath
// depends on sacp_pkg
`timescale 1ns / 1ps
module sacp_dp
    import sacp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_req       i_req,
    input  logic [3:0] i_offset_bits,
    input  logic [2:0] i_index_bits,
    output logic       o_clr_last,
    output t_rsp       o_rsp
);
    // per-set state kept in one memory word
    typedef struct packed {
        logic [WAYS-1:0]   valid;
        logic [TREE_W-1:0] plru;
        logic [FILL_W-1:0] fill;
    } t_meta;

    logic [WAYS*64-1:0] r_tag_mem [SETS];
    t_meta r_meta [SETS];
    logic [CNT_W-1:0] r_cnt [6];

    logic [SET_W-1:0] n_set, r_set;
    logic [63:0] n_tag, r_tag;
    logic r_wr;
    logic [WAYS*64-1:0] r_line;
    t_meta r_cur;
    logic [SET_W-1:0] r_clr;
    t_rsp r_rsp;

    logic [63:0] a;
    always_comb begin
        a = i_req.address >> i_offset_bits;
        n_set = SET_W'(a & ((64'd1 << i_index_bits) - 64'd1));
        n_tag = a >> i_index_bits;
    end

    // clearing pass over all sets after reset
    assign o_clr_last = (r_clr == SET_W'(SETS - 1));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= n_set;
            r_tag <= n_tag;
            r_wr <= i_req.operation;
            r_line <= r_tag_mem[n_set];
            r_cur <= r_meta[n_set];
        end
    end

    logic hit;
    logic free;
    logic [WAY_W-1:0] hw, fw, way;
    logic [1:0] act;
    logic [WAYS-1:0] vld;
    always_comb begin
        vld = r_cur.valid;
        hit = 1'b0;
        hw = '0;
        free = 1'b0;
        fw = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (vld[w] && r_line[w*64 +: 64] == r_tag) begin
                hit = 1'b1;
                hw = WAY_W'(w);
            end
            if (!vld[w]) begin
                free = 1'b1;
                fw = WAY_W'(w);
            end
        end
        if (hit) begin
            way = hw;
            act = ACT_HIT;
        end else if (int'(r_cur.fill) < WAYS && free) begin
            way = fw;
            act = ACT_FILL;
        end else begin
            way = tree_victim(r_cur.plru);
            act = ACT_REPLACE;
        end
    end

    logic [WAYS*64-1:0] n_line;
    always_comb begin
        n_line = r_line;
        n_line[int'(way)*64 +: 64] = r_tag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && !hit)
            r_tag_mem[r_set] <= n_line;
    end

    t_meta n_meta;
    always_comb begin
        n_meta.valid = r_cur.valid;
        n_meta.plru = tree_touch(r_cur.plru, way);
        n_meta.fill = r_cur.fill;
        if (!hit) begin
            n_meta.valid[way] = 1'b1;
            if (int'(r_cur.fill) < WAYS) n_meta.fill = r_cur.fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_meta[r_clr] <= '0;
        end else if (i_cmd.update) begin
            r_meta[r_set] <= n_meta;
        end
    end

    function automatic logic [CNT_W-1:0] sat(input logic [CNT_W-1:0] v, input logic en);
        return (en && v != '1) ? v + 1'b1 : v;
    endfunction

    logic [CNT_W-1:0] n_cnt [6];
    always_comb begin
        n_cnt[0] = sat(r_cnt[0], 1'b1);
        n_cnt[1] = sat(r_cnt[1], !r_wr);
        n_cnt[2] = sat(r_cnt[2], r_wr);
        n_cnt[3] = sat(r_cnt[3], !hit);
        n_cnt[4] = sat(r_cnt[4], !hit && !r_wr);
        n_cnt[5] = sat(r_cnt[5], !hit && r_wr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_cnt[k] <= '0;
        end else if (i_cmd.update) begin
            for (int k = 0; k < 6; k++) r_cnt[k] <= n_cnt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rsp.hit <= hit;
            r_rsp.way <= 3'(way);
            r_rsp.action <= act;
            r_rsp.access_count <= n_cnt[0];
            r_rsp.read_count <= n_cnt[1];
            r_rsp.write_count <= n_cnt[2];
            r_rsp.miss_count <= n_cnt[3];
            r_rsp.read_miss_count <= n_cnt[4];
            r_rsp.write_miss_count <= n_cnt[5];
        end
    end
    assign o_rsp = r_rsp;
endmodule
